>>> hw/rtl/gyro_bias_calibrate_correct_assert.svh
// assertion macros shared by the gyro bias calibration rtl
`ifndef GYRO_BIAS_CALIBRATE_CORRECT_ASSERT_SVH
`define GYRO_BIAS_CALIBRATE_CORRECT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GBC_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("gbc assertion failed");

// next-cycle implication, checked outside reset
`define GBC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("gbc assertion failed");

`endif

>>> hw/rtl/gbc_pkg.sv
// types and constants shared by the gyro bias calibration blocks
package gbc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BOUND_W    = 15;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int COARSE_RESET = 200;
  localparam int FINE_RESET   = 500;
  localparam int BOUND_RESET  = 10;

  typedef logic [1:0] gbc_reg_idx_t;
  localparam gbc_reg_idx_t REG_COARSE = 2'd0;
  localparam gbc_reg_idx_t REG_FINE   = 2'd1;
  localparam gbc_reg_idx_t REG_BOUND  = 2'd2;

  typedef enum logic [1:0] {
    PH_UNCAL   = 2'd0,
    PH_COARSE  = 2'd1,
    PH_FINE    = 2'd2,
    PH_CORRECT = 2'd3
  } gbc_phase_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } gbc_state_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic bias_load;
  } gbc_cmd_t;

  typedef struct packed {
    logic phase_end;
    logic div_done;
  } gbc_sts_t;

  typedef struct packed {
    logic [2:0]          empty;
    gbc_phase_t          phase;
    logic [SAMPLE_W-1:0] z;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] x;
  } gbc_res_t;

endpackage

>>> hw/rtl/gbc_div.sv
// three-lane restoring divider, signed dividend by unsigned divisor, one bit per cycle
`include "gyro_bias_calibrate_correct_assert.svh"

module gbc_div import gbc_pkg::*; #(
  parameter int SUM_W = 27,
  parameter int DIV_W = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [2:0]                 lane_en_in,
  input  logic signed [SUM_W-1:0]    dividend [3],
  input  logic [DIV_W-1:0]           divisor [3],
  output logic                       done,
  output logic [2:0]                 lane_en,
  output logic signed [SAMPLE_W-1:0] quotient [3]
);

  localparam int ITER_W = $clog2(SUM_W);

  logic              busy;
  logic [ITER_W-1:0] iter;
  logic [SUM_W-1:0]  quo [3];
  logic [DIV_W-1:0]  rem [3];
  logic [DIV_W-1:0]  dvs [3];
  logic [2:0]        neg;

  logic [DIV_W:0]    rem_sh [3];
  logic [2:0]        ge;
  logic [DIV_W-1:0]  rem_next [3];
  logic [SUM_W-1:0]  mag [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]      = dividend[k][SUM_W-1] ? SUM_W'(-dividend[k]) : SUM_W'(dividend[k]);
      rem_sh[k]   = {rem[k], quo[k][SUM_W-1]};
      ge[k]       = rem_sh[k] >= {1'b0, dvs[k]};
      rem_next[k] = ge[k] ? DIV_W'(rem_sh[k] - {1'b0, dvs[k]}) : DIV_W'(rem_sh[k]);
      quotient[k] = neg[k] ? -$signed(quo[k][SAMPLE_W-1:0]) : $signed(quo[k][SAMPLE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      iter    <= '0;
      lane_en <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        iter    <= '0;
        lane_en <= lane_en_in;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == ITER_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (start) begin
        quo[k] <= mag[k];
        rem[k] <= '0;
        dvs[k] <= divisor[k];
        neg[k] <= dividend[k][SUM_W-1];
      end else if (busy) begin
        quo[k] <= {quo[k][SUM_W-2:0], ge[k]};
        rem[k] <= rem_next[k];
      end
    end
  end

  `GBC_ASSERT_NEXT(a_start_runs, clk, rst, start, busy)

endmodule

>>> hw/rtl/gbc_dp.sv
// datapath: accumulators, outlier window, bias registers and correction
module gbc_dp import gbc_pkg::*; #(
  parameter int COUNT_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gbc_cmd_t                   cmd,
  output gbc_sts_t                   sts,
  input  logic signed [SAMPLE_W-1:0] rate_x,
  input  logic signed [SAMPLE_W-1:0] rate_y,
  input  logic signed [SAMPLE_W-1:0] rate_z,
  input  logic                       restart_cal,
  input  logic [COUNT_BITS-1:0]      coarse_count,
  input  logic [COUNT_BITS-1:0]      fine_count,
  input  logic [BOUND_W-1:0]         accept_bound,
  output gbc_res_t                   result
);

  localparam int SUM_W = COUNT_BITS + 17;
  localparam int DIV_W = COUNT_BITS + 1;

  gbc_phase_t                 phase;
  logic [COUNT_BITS-1:0]      sample_count;
  logic signed [SUM_W-1:0]    axis_sum [3];
  logic [DIV_W-1:0]           accept_count [3];
  logic signed [SAMPLE_W-1:0] axis_bias [3];
  logic [2:0]                 empty_flags;

  logic signed [SAMPLE_W-1:0] raw [3];
  gbc_phase_t                 ph_eff;
  gbc_phase_t                 phase_next;
  logic [COUNT_BITS-1:0]      cnt_eff;
  logic [COUNT_BITS-1:0]      cnt_inc;
  logic [COUNT_BITS-1:0]      limit;
  logic [COUNT_BITS-1:0]      limit_eff;
  logic                       cnt_end;
  logic                       in_calib;
  logic [2:0]                 flags_eff;
  logic [2:0]                 empty_new;
  logic signed [SAMPLE_W:0]   bound_s;
  logic signed [SAMPLE_W-1:0] bias_eff [3];
  logic signed [SUM_W-1:0]    sum_eff [3];
  logic signed [SUM_W-1:0]    sum_add [3];
  logic [DIV_W-1:0]           acc_eff [3];
  logic [DIV_W-1:0]           acc_add [3];
  logic signed [SAMPLE_W:0]   diff [3];
  logic [2:0]                 in_win;
  logic [2:0]                 zero_acc;
  logic [SAMPLE_W-1:0]        corr [3];
  logic [2:0]                 div_en;
  logic [DIV_W-1:0]           divisor [3];
  logic [2:0]                 lane_en;
  logic signed [SAMPLE_W-1:0] quotient [3];
  logic                       div_done;

  assign raw[0] = rate_x;
  assign raw[1] = rate_y;
  assign raw[2] = rate_z;

  always_comb begin
    ph_eff    = restart_cal ? PH_COARSE : phase;
    cnt_eff   = restart_cal ? '0 : sample_count;
    flags_eff = restart_cal ? '0 : empty_flags;
    cnt_inc   = cnt_eff + 1'b1;
    limit     = (ph_eff == PH_COARSE) ? coarse_count : fine_count;
    limit_eff = (limit == '0) ? COUNT_BITS'(1) : limit;
    // a wrapped count means the full 2^COUNT_BITS samples were seen
    cnt_end   = (cnt_inc >= limit_eff) || (cnt_inc == '0);
    in_calib  = (ph_eff == PH_COARSE) || (ph_eff == PH_FINE);
    bound_s   = $signed({2'b00, accept_bound});
    for (int k = 0; k < 3; k++) begin
      bias_eff[k] = restart_cal ? '0 : axis_bias[k];
      sum_eff[k]  = restart_cal ? '0 : axis_sum[k];
      acc_eff[k]  = restart_cal ? '0 : accept_count[k];
      diff[k]     = (SAMPLE_W+1)'(raw[k]) - (SAMPLE_W+1)'(bias_eff[k]);
      in_win[k]   = (diff[k] >= -bound_s) && (diff[k] <= bound_s);
      if ((ph_eff == PH_COARSE) || ((ph_eff == PH_FINE) && in_win[k])) begin
        sum_add[k] = sum_eff[k] + SUM_W'(raw[k]);
      end else begin
        sum_add[k] = sum_eff[k];
      end
      acc_add[k]  = ((ph_eff == PH_FINE) && in_win[k]) ? acc_eff[k] + 1'b1 : acc_eff[k];
      zero_acc[k] = (acc_add[k] == '0);
      corr[k]     = SAMPLE_W'(raw[k] - bias_eff[k]);
      divisor[k]  = (ph_eff == PH_COARSE) ? {cnt_inc == '0, cnt_inc} : acc_add[k];
    end
    div_en    = (ph_eff == PH_COARSE) ? 3'b111 : ~zero_acc;
    empty_new = flags_eff | (((ph_eff == PH_FINE) && cnt_end) ? zero_acc : 3'b000);
  end

  always_comb begin
    case (ph_eff)
      PH_COARSE: phase_next = cnt_end ? PH_FINE : PH_COARSE;
      PH_FINE:   phase_next = cnt_end ? PH_CORRECT : PH_FINE;
      default:   phase_next = ph_eff;
    endcase
  end

  always_comb begin
    result.empty = empty_new;
    result.phase = ph_eff;
    if (ph_eff == PH_CORRECT) begin
      result.x = corr[0];
      result.y = corr[1];
      result.z = corr[2];
    end else begin
      result.x = raw[0];
      result.y = raw[1];
      result.z = raw[2];
    end
  end

  assign sts = '{phase_end: in_calib && cnt_end, div_done: div_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_UNCAL;
      sample_count <= '0;
      empty_flags  <= '0;
      for (int k = 0; k < 3; k++) begin
        axis_sum[k]     <= '0;
        accept_count[k] <= '0;
        axis_bias[k]    <= '0;
      end
    end else if (cmd.accept) begin
      phase       <= phase_next;
      empty_flags <= empty_new;
      if (sts.phase_end) begin
        sample_count <= '0;
      end else if (in_calib) begin
        sample_count <= cnt_inc;
      end else begin
        sample_count <= cnt_eff;
      end
      for (int k = 0; k < 3; k++) begin
        axis_bias[k] <= bias_eff[k];
        if (sts.phase_end) begin
          axis_sum[k]     <= '0;
          accept_count[k] <= '0;
        end else begin
          axis_sum[k]     <= sum_add[k];
          accept_count[k] <= acc_add[k];
        end
      end
    end else if (cmd.bias_load) begin
      // lanes that accepted nothing keep the coarse bias
      for (int k = 0; k < 3; k++) begin
        if (lane_en[k]) begin
          axis_bias[k] <= quotient[k];
        end
      end
    end
  end

  gbc_div #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start),
    .lane_en_in (div_en),
    .dividend   (sum_add),
    .divisor    (divisor),
    .done       (div_done),
    .lane_en    (lane_en),
    .quotient   (quotient)
  );

endmodule

>>> hw/rtl/gbc_ctrl.sv
// controller: accepts samples and waits out the bias division at phase ends
`include "gyro_bias_calibrate_correct_assert.svh"

module gbc_ctrl import gbc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_space,
  output logic     in_ready,
  input  gbc_sts_t sts,
  output gbc_cmd_t cmd
);

  gbc_state_t state;
  gbc_state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && out_space && sts.phase_end) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (sts.div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.bias_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = out_space;
        cmd.accept    = in_valid && out_space;
        cmd.div_start = in_valid && out_space && sts.phase_end;
      end
      ST_DIVIDE: begin
        cmd.bias_load = sts.div_done;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `GBC_ASSERT_IMPL(a_no_accept_in_divide, clk, rst, state == ST_DIVIDE, !cmd.accept)
  `GBC_ASSERT_IMPL(a_done_only_in_divide, clk, rst, sts.div_done, state == ST_DIVIDE)

endmodule

>>> hw/rtl/gyro_bias_calibrate_correct.sv
// top level: config registers, stream ports and two-entry result buffer
// results: each result is written into the result buffer when its input transaction is accepted
// throughput: one sample per cycle while the result buffer has space; a sample that
//   ends the coarse or fine phase holds off the next one while the bit-serial
//   divider computes the three biases
// reset: synchronous, clears phase, accumulators, biases and flags; registers
//   return to 200, 500 and 10
`include "gyro_bias_calibrate_correct_assert.svh"

module gyro_bias_calibrate_correct import gbc_pkg::*; #(
  parameter int COUNT_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // rate_x, rate_y, rate_z
  input  logic                  s_tuser,   // restart_cal
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,   // out_x, out_y, out_z
  output logic [4:0]            m_tuser,   // cal_phase, empty_axis_flag
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [COUNT_BITS-1:0] coarse_count;
  logic [COUNT_BITS-1:0] fine_count;
  logic [BOUND_W-1:0]    accept_bound;
  gbc_reg_idx_t          reg_idx;
  logic                  reg_wr;

  gbc_cmd_t cmd;
  gbc_sts_t sts;
  gbc_res_t result;

  gbc_res_t   buf0;
  gbc_res_t   buf1;
  logic [1:0] buf_cnt;
  logic       push;
  logic       pop;

  // configuration
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coarse_count <= COUNT_BITS'(COARSE_RESET);
      fine_count   <= COUNT_BITS'(FINE_RESET);
      accept_bound <= BOUND_W'(BOUND_RESET);
    end else if (reg_wr) begin
      case (reg_idx)
        REG_COARSE: coarse_count <= pwdata[COUNT_BITS-1:0];
        REG_FINE:   fine_count   <= pwdata[COUNT_BITS-1:0];
        REG_BOUND:  accept_bound <= pwdata[BOUND_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COARSE: prdata = APB_DATA_W'(coarse_count);
      REG_FINE:   prdata = APB_DATA_W'(fine_count);
      REG_BOUND:  prdata = APB_DATA_W'(accept_bound);
      default:    prdata = '0;
    endcase
  end

  gbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_space (buf_cnt != 2'd2),
    .in_ready  (s_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbc_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .rate_x       (s_tdata[15:0]),
    .rate_y       (s_tdata[31:16]),
    .rate_z       (s_tdata[47:32]),
    .restart_cal  (s_tuser),
    .coarse_count (coarse_count),
    .fine_count   (fine_count),
    .accept_bound (accept_bound),
    .result       (result)
  );

  // result buffer, head entry drives the master side
  assign push     = cmd.accept;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (buf_cnt != 2'd0);
  assign m_tdata  = {buf0.z, buf0.y, buf0.x};
  assign m_tuser  = {buf0.empty, buf0.phase};

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   buf_cnt <= buf_cnt + 2'd1;
        2'b01:   buf_cnt <= buf_cnt - 2'd1;
        default: buf_cnt <= buf_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (buf_cnt == 2'd0) begin
          buf0 <= result;
        end else begin
          buf1 <= result;
        end
      end
      2'b01: begin
        buf0 <= buf1;
      end
      2'b11: begin
        if (buf_cnt == 2'd1) begin
          buf0 <= result;
        end else begin
          buf0 <= buf1;
          buf1 <= result;
        end
      end
      default: ;
    endcase
  end

  `GBC_ASSERT_NEXT(a_result_follows, clk, rst, s_tvalid && s_tready, m_tvalid)
  `GBC_ASSERT_IMPL(a_full_stalls_input, clk, rst, buf_cnt == 2'd2, !s_tready)

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// testbench for the gyro bias calibration and correction block
module tb;
  import gbc_pkg::*;

  localparam int COUNT_BITS    = 10;
  localparam int SETTLE_CYCLES = COUNT_BITS + 18 + 6;
  localparam int RANDOM_ITEMS  = 750;

  // tracks calibration state and holds the output samples still owed by the block
  class gyro_cal_tracker;
    gbc_res_t              predicted_samples[$];
    int unsigned           errors;
    logic [COUNT_BITS-1:0] coarse_n;
    logic [COUNT_BITS-1:0] fine_n;
    logic [BOUND_W-1:0]    bound;
    gbc_phase_t            phase;
    logic [COUNT_BITS-1:0] seen;
    longint                axis_sum[3];
    int                    accepted[3];
    int                    bias[3];
    logic [2:0]            empty;

    function new();
      coarse_n = COUNT_BITS'(COARSE_RESET);
      fine_n   = COUNT_BITS'(FINE_RESET);
      bound    = BOUND_W'(BOUND_RESET);
      phase    = PH_UNCAL;
      clear_sums();
      bias     = '{0, 0, 0};
      empty    = '0;
      errors   = 0;
    endfunction

    function void clear_sums();
      seen = '0;
      for (int k = 0; k < 3; k++) begin
        axis_sum[k] = 0;
        accepted[k] = 0;
      end
    endfunction

    function void set_reg(gbc_reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_COARSE: coarse_n = value[COUNT_BITS-1:0];
        REG_FINE:   fine_n   = value[COUNT_BITS-1:0];
        REG_BOUND:  bound    = value[BOUND_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return predicted_samples.size();
    endfunction

    function void note_sample(logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
                              logic restart);
      int         raw[3];
      int         res[3];
      int         lim;
      int         d;
      int         b;
      longint     n;
      gbc_phase_t handled;
      gbc_res_t   want;
      raw[0] = int'($signed(rx));
      raw[1] = int'($signed(ry));
      raw[2] = int'($signed(rz));
      if (restart) begin
        phase = PH_COARSE;
        clear_sums();
        bias  = '{0, 0, 0};
        empty = '0;
      end
      handled = phase;
      res = raw;
      case (phase)
        PH_COARSE: begin
          for (int k = 0; k < 3; k++) axis_sum[k] += raw[k];
          seen = seen + 1'b1;
          lim = (coarse_n == '0) ? 1 : int'(coarse_n);
          if (int'(seen) >= lim || seen == '0) begin
            n = (seen == '0) ? (longint'(1) << COUNT_BITS) : longint'(seen);
            for (int k = 0; k < 3; k++) bias[k] = int'(axis_sum[k] / n);
            clear_sums();
            phase = PH_FINE;
          end
        end
        PH_FINE: begin
          b = int'(bound);
          for (int k = 0; k < 3; k++) begin
            d = raw[k] - bias[k];
            if (d >= -b && d <= b) begin
              axis_sum[k] += raw[k];
              accepted[k]++;
            end
          end
          seen = seen + 1'b1;
          lim = (fine_n == '0) ? 1 : int'(fine_n);
          if (int'(seen) >= lim || seen == '0) begin
            for (int k = 0; k < 3; k++) begin
              if (accepted[k] > 0)
                bias[k] = int'(axis_sum[k] / longint'(accepted[k]));
              else
                empty[k] = 1'b1;
            end
            clear_sums();
            phase = PH_CORRECT;
          end
        end
        PH_CORRECT: begin
          for (int k = 0; k < 3; k++) res[k] = raw[k] - bias[k];
        end
        default: ;
      endcase
      want.x     = 16'(res[0]);
      want.y     = 16'(res[1]);
      want.z     = 16'(res[2]);
      want.phase = handled;
      want.empty = empty;
      predicted_samples.push_back(want);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_output(logic [47:0] data, logic [4:0] user);
      gbc_res_t want;
      if (predicted_samples.size() == 0) begin
        $display("%0t: output transaction with nothing expected: %h %h", $time, data, user);
        errors++;
        return;
      end
      want = predicted_samples.pop_front();
      check_field("out_x", want.x, data[15:0]);
      check_field("out_y", want.y, data[31:16]);
      check_field("out_z", want.z, data[47:32]);
      check_field("cal_phase", want.phase, user[1:0]);
      check_field("empty_axis_flag", want.empty, user[4:2]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [47:0]           s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [47:0]           m_tdata;
  logic [4:0]            m_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  gyro_cal_tracker calib;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  gyro_bias_calibrate_correct #(.COUNT_BITS(COUNT_BITS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("gyro_bias_calibrate_correct: mismatch");
    $finish;
  end

  // output side: check each transaction, then pick the next ready value
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) calib.check_output(m_tdata, m_tuser);
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_item(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                           input logic restart);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
    calib.note_sample(x, y, z, restart);
  endtask

  task automatic reg_write(input gbc_reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    calib.set_reg(idx, value);
  endtask

  // hold off the sender until every output has come back and the divider is done
  task automatic settle();
    s_tvalid <= 1'b0;
    while (calib.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] jitter(logic [15:0] center, int spread);
    return center + 16'(int'($urandom_range(2 * spread)) - spread);
  endfunction

  initial begin
    int          seg;
    int          n_random;
    int          len;
    int          mode;
    int          spread[3];
    logic [15:0] center[3];
    logic [15:0] s[3];
    logic        restart;

    calib = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // uncalibrated: samples pass straight through
    send_item(16'h7fff, 16'h8000, 16'h0000, 1'b0);
    send_item(16'hffff, 16'h0001, 16'h8000, 1'b0);
    settle();

    // zero counts act as one, zero bound rejects all but an exact match
    reg_write(REG_COARSE, 0);
    reg_write(REG_FINE, 0);
    reg_write(REG_BOUND, 0);
    send_item(16'h8000, 16'h7fff, 16'h0005, 1'b1);
    send_item(16'h8000, 16'h7fff, 16'h0006, 1'b0);  // z rejected, coarse bias kept
    send_item(16'h7fff, 16'h8000, 16'h0000, 1'b0);  // correction wraps
    send_item(16'hffff, 16'h0000, 16'h8000, 1'b0);
    settle();

    // long coarse phase cut short by lowering the count
    reg_write(REG_COARSE, 1023);
    reg_write(REG_FINE, 3);
    reg_write(REG_BOUND, 32767);
    send_item(16'h8000, 16'h7fff, 16'hfffd, 1'b1);
    send_item(16'h8000, 16'h7fff, 16'hfffc, 1'b0);
    send_item(16'h0001, 16'h8000, 16'h0000, 1'b0);
    settle();
    reg_write(REG_COARSE, 2);
    send_item(16'h0003, 16'hffff, 16'h7fff, 1'b0);
    send_item(16'h7fff, 16'h8000, 16'hffff, 1'b0);
    settle();
    reg_write(REG_FINE, 1023);
    send_item(16'h8000, 16'h7fff, 16'h0001, 1'b0);
    settle();
    reg_write(REG_FINE, 1);
    send_item(16'h1234, 16'hedcb, 16'h0000, 1'b0);
    send_item(16'h7fff, 16'h8000, 16'h0000, 1'b0);
    settle();

    // restart in the middle of the coarse, fine and correcting phases
    reg_write(REG_COARSE, 2);
    reg_write(REG_FINE, 2);
    reg_write(REG_BOUND, 10);
    send_item(16'h0010, 16'hfff0, 16'h0100, 1'b1);
    send_item(16'h0011, 16'hffef, 16'h0101, 1'b1);
    send_item(16'h0012, 16'hffee, 16'h0102, 1'b0);
    send_item(16'h001c, 16'hfff0, 16'h0200, 1'b0);
    send_item(16'h0013, 16'hffe0, 16'h0100, 1'b1);
    send_item(16'h0014, 16'hffe1, 16'h0101, 1'b0);
    send_item(16'h0015, 16'hffe2, 16'h0102, 1'b0);
    send_item(16'h0016, 16'hffe3, 16'h0140, 1'b0);
    send_item(16'h8000, 16'h7fff, 16'h0000, 1'b0);
    send_item(16'h0017, 16'hffe4, 16'h0103, 1'b1);

    seg = 0;
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      settle();
      mode = seg % 4;
      src_idle_pct   = (mode == 1) ? 63 : (mode == 3) ? 22 : 0;
      sink_stall_pct = (mode == 2) ? 63 : (mode == 3) ? 22 : 0;
      if ($urandom_range(2) != 0)
        reg_write(REG_COARSE, ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12));
      if ($urandom_range(2) != 0)
        reg_write(REG_FINE, ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 16));
      if ($urandom_range(2) != 0) begin
        case ($urandom_range(3))
          0: reg_write(REG_BOUND, 0);
          1: reg_write(REG_BOUND, 32767);
          2: reg_write(REG_BOUND, $urandom_range(1, 40));
          default: reg_write(REG_BOUND, $urandom_range(0, 32767));
        endcase
      end
      for (int k = 0; k < 3; k++) begin
        center[k] = 16'($urandom);
        case ($urandom_range(3))
          0: spread[k] = 0;
          1: spread[k] = $urandom_range(1, 16);
          2: spread[k] = $urandom_range(17, 400);
          default: spread[k] = 32767;
        endcase
      end
      len = int'(calib.coarse_n) + int'(calib.fine_n) + $urandom_range(0, 20);
      for (int i = 0; i < len; i++) begin
        restart = (i == 0) ? ($urandom_range(7) != 0) : ($urandom_range(39) == 0);
        for (int k = 0; k < 3; k++)
          s[k] = ($urandom_range(29) == 0) ? 16'($urandom) : jitter(center[k], spread[k]);
        send_item(s[0], s[1], s[2], restart);
        n_random++;
      end
      seg++;
    end

    settle();
    if (calib.errors == 0 && calib.pending() == 0) begin
      $display("gyro_bias_calibrate_correct: match");
    end else begin
      $display("gyro_bias_calibrate_correct: mismatch");
    end
    $finish;
  end

endmodule
